// File: design/mbrtu_pkg.sv
// Shared constants and types for the Modbus RTU request framer.
package mbrtu_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned MAX_DATA_BYTES = 9;
    localparam int unsigned FRAME_BITS = MAX_DATA_BYTES * BYTE_W;
    localparam int unsigned LEFT_W = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Frame kinds carried in tuser
    localparam logic [1:0] CMD_STANDARD = 2'd0;
    localparam logic [1:0] CMD_WRITE_MULTI = 2'd1;
    localparam logic [1:0] CMD_SHORT = 2'd2;

    // Data bytes ahead of the CRC for each kind
    localparam logic [LEFT_W-1:0] LEN_STANDARD = 4'd6;
    localparam logic [LEFT_W-1:0] LEN_WRITE_MULTI = 4'd9;
    localparam logic [LEFT_W-1:0] LEN_SHORT = 4'd5;

    // Fixed bytes of a write-multiple of one register
    localparam logic [7:0] QTY_HI = 8'h00;
    localparam logic [7:0] QTY_LO = 8'h01;
    localparam logic [7:0] BYTE_COUNT = 8'h01;

    typedef struct packed {
        logic init;   // restart the CRC at 0xFFFF
        logic load;   // take a new byte and run eight bit steps
    } crc_ctl_t;

endpackage

// File: design/mbrtu_crc.sv
// Bit-serial CRC-16/MODBUS unit: one bit of the loaded byte per cycle.
module mbrtu_crc
(
    input  logic                clk,
    input  logic                rst_n,
    input  mbrtu_pkg::crc_ctl_t ctl,
    input  logic [7:0]          data,
    output logic                step_last,
    output logic [15:0]         crc
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  bits_reg, bits_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        fb;

    assign fb = crc_reg[0] ^ bits_reg[0];

    always_comb
    begin
        crc_next  = crc_reg;
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctl.init)
        begin
            crc_next  = mbrtu_pkg::CRC_INIT;
            busy_next = 1'b0;
        end
        else if (ctl.load)
        begin
            bits_next = data;
            cnt_next  = 3'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift one bit, fold in the reflected polynomial on feedback
            crc_next  = (crc_reg >> 1) ^ (fb ? mbrtu_pkg::CRC_POLY : 16'h0000);
            bits_next = bits_reg >> 1;
            cnt_next  = cnt_reg + 3'd1;
            busy_next = (cnt_reg != 3'd7);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= mbrtu_pkg::CRC_INIT;
            bits_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            crc_reg  <= crc_next;
            bits_reg <= bits_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign step_last = busy_reg && (cnt_reg == 3'd7);
    assign crc       = crc_reg;

endmodule

// File: design/modbus_rtu_request_framer.sv
// Top level of the Modbus RTU request framer: byte sequencer and output register.
//
// Each accepted request becomes one Modbus RTU frame sent one byte per transaction on the
// master side, tlast high on the CRC high byte. Kind 0 gives 8 bytes, kind 1 gives 11,
// kind 2 gives 7; kind 3 is dropped with no output. The CRC-16/MODBUS runs one bit per
// cycle; each data byte is put in the output register and then fed through the CRC before
// the next byte is sent, and the two CRC bytes follow the data. A new request is taken only
// once the previous frame's last byte sits in the output register; that byte may still be
// waiting for the sink.
module modbus_rtu_request_framer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] slave_address, [15:8] function_code, [31:16] start_register,
    // [47:32] payload
    input  logic [47:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] frame_byte
    output logic [7:0]  m_axis_tdata,
    // last_byte
    output logic        m_axis_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEND,
        ST_FEED,
        ST_CRC_LO,
        ST_CRC_HI
    } state_t;

    state_t state_reg, state_next;
    logic [mbrtu_pkg::FRAME_BITS-1:0] frame_reg, frame_next;
    logic [mbrtu_pkg::LEFT_W-1:0]     left_reg, left_next;
    logic [7:0]  tdata_reg, tdata_next;
    logic        tlast_reg, tlast_next;
    logic        tvalid_reg, tvalid_next;

    logic        in_xfer;
    logic        slot_free;
    logic        crc_step_last;
    logic [15:0] crc;
    mbrtu_pkg::crc_ctl_t crc_ctl;

    logic [7:0]  addr, fcode, reg_hi, reg_lo, pay_hi, pay_lo;

    assign addr   = s_axis_tdata[7:0];
    assign fcode  = s_axis_tdata[15:8];
    assign reg_hi = s_axis_tdata[31:24];
    assign reg_lo = s_axis_tdata[23:16];
    assign pay_hi = s_axis_tdata[47:40];
    assign pay_lo = s_axis_tdata[39:32];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !tvalid_reg || m_axis_tready;

    mbrtu_crc u_crc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (crc_ctl),
        .data      (frame_reg[7:0]),
        .step_last (crc_step_last),
        .crc       (crc)
    );

    always_comb
    begin
        state_next  = state_reg;
        frame_next  = frame_reg;
        left_next   = left_reg;
        tdata_next  = tdata_reg;
        tlast_next  = tlast_reg;
        tvalid_next = tvalid_reg;
        crc_ctl     = '0;

        // drop the held byte once the sink takes it
        if (tvalid_reg && m_axis_tready)
        begin
            tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (s_axis_tuser)
                        mbrtu_pkg::CMD_STANDARD:
                        begin
                            frame_next = {24'd0, pay_lo, pay_hi, reg_lo, reg_hi, fcode, addr};
                            left_next  = mbrtu_pkg::LEN_STANDARD;
                            state_next = ST_SEND;
                            crc_ctl.init = 1'b1;
                        end
                        mbrtu_pkg::CMD_WRITE_MULTI:
                        begin
                            frame_next = {pay_lo, pay_hi, mbrtu_pkg::BYTE_COUNT,
                                          mbrtu_pkg::QTY_LO, mbrtu_pkg::QTY_HI,
                                          reg_lo, reg_hi, fcode, addr};
                            left_next  = mbrtu_pkg::LEN_WRITE_MULTI;
                            state_next = ST_SEND;
                            crc_ctl.init = 1'b1;
                        end
                        mbrtu_pkg::CMD_SHORT:
                        begin
                            frame_next = {32'd0, pay_lo, reg_lo, reg_hi, fcode, addr};
                            left_next  = mbrtu_pkg::LEN_SHORT;
                            state_next = ST_SEND;
                            crc_ctl.init = 1'b1;
                        end
                        default:
                        begin
                            // unknown kind: drop the transaction
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEND:
            begin
                if (slot_free)
                begin
                    tdata_next  = frame_reg[7:0];
                    tlast_next  = 1'b0;
                    tvalid_next = 1'b1;
                    crc_ctl.load = 1'b1;
                    state_next  = ST_FEED;
                end
            end
            ST_FEED:
            begin
                if (crc_step_last)
                begin
                    frame_next = frame_reg >> mbrtu_pkg::BYTE_W;
                    left_next  = left_reg - 4'd1;
                    state_next = (left_reg == 4'd1) ? ST_CRC_LO : ST_SEND;
                end
            end
            ST_CRC_LO:
            begin
                if (slot_free)
                begin
                    tdata_next  = crc[7:0];
                    tlast_next  = 1'b0;
                    tvalid_next = 1'b1;
                    state_next  = ST_CRC_HI;
                end
            end
            ST_CRC_HI:
            begin
                if (slot_free)
                begin
                    tdata_next  = crc[15:8];
                    tlast_next  = 1'b1;
                    tvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            frame_reg  <= '0;
            left_reg   <= '0;
            tdata_reg  <= '0;
            tlast_reg  <= 1'b0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            frame_reg  <= frame_next;
            left_reg   <= left_next;
            tdata_reg  <= tdata_next;
            tlast_reg  <= tlast_next;
            tvalid_reg <= tvalid_next;
        end
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tlast  = tlast_reg;

endmodule
